### rtl/core/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // escape decoder phase
  typedef enum logic [2:0] {
    PH_TEXT = 3'd0,
    PH_ESC  = 3'd1,
    PH_HEX1 = 3'd2,
    PH_HEX2 = 3'd3,
    PH_HEX3 = 3'd4,
    PH_HEX4 = 3'd5
  } phase_t;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_BAD  = 2'd2
  } kind_t;

  localparam int unsigned JOB_BYTES = 3;
  localparam int unsigned Q_DEPTH   = 2;
  localparam logic [15:0] BAD_MARK  = 16'hFFFF;

  // work for the back end: cnt result bytes, kind applies to all of them
  typedef struct packed {
    logic [1:0]                 cnt;
    kind_t                      kind;
    logic [JOB_BYTES-1:0][7:0]  bytes;
  } jsu_job_t;

  // hex digit decode: bit 4 is the valid flag
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// JSON string body unescaper with UTF-8 output.
// ----------------------------------------------------------------------------
// One body byte is accepted per cycle. Each byte becomes a job of zero to
// three results; non-empty jobs enter a two-entry queue. With out_ready
// high the output register drains the queue at one result per cycle, so
// plain text flows at one byte per cycle via a queue entry and the output
// register. A \u escape of two or three UTF-8 bytes holds the output for
// one result transaction per byte; input stalls only once both queue
// entries are held. Unescaped quote or NUL yields kind 1; bad or 0xFFFF, 2.
`default_nettype none

module json_string_unescape_utf8 import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last
);

  jsu_job_t job;
  jsu_job_t head;
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  // byte classification and escape tracking
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .q_full   (full),
    .push     (push),
    .job      (job)
  );

  // job queue
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  // result serializer
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule

`default_nettype wire

### rtl/core/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw string bytes, tracks the escape phase and builds result jobs.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       q_full,
  output logic            push,
  output jsu_job_t        job
);

  phase_t      phase, phase_next;
  logic [15:0] code_point, code_point_next;
  logic [4:0]  hv;
  logic [15:0] cp;
  logic        take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign push     = take && (job.cnt != 2'd0);

  // classify the byte and form its job
  always_comb begin
    phase_next      = phase;
    code_point_next = code_point;
    job             = '0;
    job.kind        = KIND_DATA;
    hv              = hex_value(in_byte);
    cp              = (!hv[4] || code_point == BAD_MARK) ? BAD_MARK
                                                        : {code_point[11:0], hv[3:0]};
    case (phase)
      PH_ESC: begin
        phase_next   = PH_TEXT;
        job.cnt      = 2'd1;
        job.bytes[0] = in_byte;
        case (in_byte)
          8'h62: job.bytes[0] = 8'h08;
          8'h74: job.bytes[0] = 8'h09;
          8'h66: job.bytes[0] = 8'h0C;
          8'h6E: job.bytes[0] = 8'h0A;
          8'h72: job.bytes[0] = 8'h0D;
          8'h75: begin
            phase_next      = PH_HEX1;
            code_point_next = 16'h0000;
            job.cnt         = 2'd0;
          end
          default: ;
        endcase
      end
      PH_HEX1, PH_HEX2, PH_HEX3: begin
        code_point_next = cp;
        phase_next      = phase_t'(phase + 3'd1);
      end
      PH_HEX4: begin
        code_point_next = cp;
        phase_next      = PH_TEXT;
        if (cp == BAD_MARK) begin
          job.cnt  = 2'd1;
          job.kind = KIND_BAD;
        end else if (cp <= 16'h007F) begin
          job.cnt      = 2'd1;
          job.bytes[0] = cp[7:0];
        end else if (cp <= 16'h07FF) begin
          job.cnt      = 2'd2;
          job.bytes[0] = 8'hC0 | {3'b000, cp[10:6]};
          job.bytes[1] = 8'h80 | {2'b00, cp[5:0]};
        end else begin
          job.cnt      = 2'd3;
          job.bytes[0] = 8'hE0 | {4'b0000, cp[15:12]};
          job.bytes[1] = 8'h80 | {2'b00, cp[11:6]};
          job.bytes[2] = 8'h80 | {2'b00, cp[5:0]};
        end
      end
      default: begin
        // plain text, also the unused phase codes
        phase_next = PH_TEXT;
        job.cnt    = 2'd1;
        if (in_byte == 8'h22 || in_byte == 8'h00) begin
          job.kind = KIND_END;
        end else if (in_byte == 8'h5C) begin
          phase_next = PH_ESC;
          job.cnt    = 2'd0;
        end else begin
          job.bytes[0] = in_byte;
        end
      end
    endcase
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TEXT;
      code_point <= 16'h0000;
    end else if (take) begin
      phase      <= phase_next;
      code_point <= code_point_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Two-entry job queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_queue import jsu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  jsu_job_t      push_job,
  input  wire logic     pop,
  output logic          full,
  output logic          empty,
  output jsu_job_t      head
);

  localparam int unsigned PW = $clog2(Q_DEPTH);

  jsu_job_t       entries [Q_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(Q_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

endmodule

`default_nettype wire

### rtl/core/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Serializes queued jobs into single result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back import jsu_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       empty,
  input  jsu_job_t        head,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = !empty && (!out_valid || out_ready);
  assign is_last = (idx == head.cnt - 2'd1);
  assign pop     = load && is_last;

  // pick the byte of the current job
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.bytes[0];
      2'd1:    sel_byte = head.bytes[1];
      2'd2:    sel_byte = head.bytes[2];
      default: sel_byte = 8'h00;
    endcase
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load)                 out_valid <= 1'b1;
      else if (out_ready)       out_valid <= 1'b0;
      if (load) idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= sel_byte;
      kind     <= head.kind;
      last     <= is_last;
    end
  end

endmodule

`default_nettype wire
